// ===== hw/rtl/lru_pkg.sv =====
// Shared types and constants for the LRU residency tracker.
`timescale 1ns / 1ps
`default_nettype none
package lru_pkg;
  localparam int MaxEntries = 32;
  localparam int KeyBits = 32;
  localparam int IdxBits = $clog2(MaxEntries);
  localparam int CntBits = $clog2(MaxEntries + 1);
  localparam logic [5:0] CapacityReset = 6'd30;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    OP_PUT = 2'd0,
    OP_GET = 2'd1,
    OP_REMOVE = 2'd2,
    OP_PEEK = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [31:0] key_tag;
  } in_word_t;

  typedef struct packed {
    logic kind;
    logic [31:0] result_key;
    logic was_resident;
    logic last;
  } out_word_t;

  // Classified request handed from front to back.
  typedef struct packed {
    op_t op;
    logic [KeyBits-1:0] key;
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVICT,
    ST_STATUS
  } state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/lru_residency_tracker_core.sv =====
// Top level of the LRU residency tracker.
// Usage:
// Requests (put, get, remove, peek) enter as words on the in_ queue port:
// a word is taken at a clock edge with in_push high and in_full low. A
// two-word front queue holds requests while the back end works.
// Results leave on the out_ queue port: the oldest word is shown while
// out_empty is low and is taken when out_pop is high. Each request yields
// zero or more eviction words followed by one status word with last set.
// An accepted request is registered into the back end, whose sequencer emits
// each eviction word and then the status word, one result per cycle while
// the receiver keeps taking words; it takes the next request only once back
// in idle. A stalled receiver holds the back end while the front queue
// keeps accepting until full.
// Capacity is written through cfg_ valid/ready while the block is idle;
// ready is high only while no request is queued or in the back end and no
// result word is waiting.
// Synchronous reset empties the directory, sets capacity to 30 and clears
// both queues.
`timescale 1ns / 1ps
`default_nettype none
module lru_residency_tracker_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire lru_pkg::in_word_t in_word,
  output logic                   in_full,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output lru_pkg::out_word_t     out_word,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [5:0]        cfg_data
);
  import lru_pkg::*;

  logic       q_valid, q_take, busy;
  req_t       q_req;
  logic [5:0] cap_r;

  assign cfg_ready = !busy && !q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= CapacityReset;
    else if (cfg_valid && cfg_ready) cap_r <= cfg_data;
  end

  lru_front u_front (
    .clk, .rst_n, .in_push, .in_word, .in_full,
    .q_valid, .q_req, .q_take
  );

  lru_back u_back (
    .clk, .rst_n, .cap(cap_r), .q_valid, .q_req, .q_take, .busy,
    .out_empty, .out_word, .out_pop
  );

  property p_cfg_idle;
    @(posedge clk) disable iff (!rst_n) (cfg_valid && cfg_ready) |-> !busy;
  endproperty
  a_cfg_idle: assert property (p_cfg_idle) else $error("cfg");

  property p_cap_load;
    @(posedge clk) disable iff (!rst_n)
      (cfg_valid && cfg_ready) |=> cap_r == $past(cfg_data);
  endproperty
  a_cap_load: assert property (p_cap_load) else $error("cap");

  property p_take_needs_valid;
    @(posedge clk) disable iff (!rst_n) q_take |-> q_valid;
  endproperty
  a_take_needs_valid: assert property (p_take_needs_valid) else $error("take");
endmodule
`default_nettype wire

// ===== hw/rtl/lru_front.sv =====
// Front end: accepts request words into a short queue.
`timescale 1ns / 1ps
`default_nettype none
module lru_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  input  wire lru_pkg::in_word_t in_word,
  output logic                  in_full,
  output logic                  q_valid,
  output lru_pkg::req_t         q_req,
  input  wire logic             q_take
);
  import lru_pkg::*;

  req_t             buf_r [QDepth];
  logic [0:0]       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign in_full = (cnt_r == 2'(QDepth));
  assign q_valid = (cnt_r != 2'd0);
  assign q_req   = buf_r[rd_r];
  assign do_push = in_push && !in_full;
  assign do_pop  = q_take && q_valid;

  always_comb begin
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= '0;
      wr_r <= '0;
      cnt_r <= '0;
    end else begin
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wr_r] <= '{op: op_t'(in_word.opcode), key: in_word.key_tag[KeyBits-1:0]};
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (!rst_n) cnt_r <= 2'(QDepth);
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

  property p_pop_drops;
    @(posedge clk) disable iff (!rst_n) (do_pop && !do_push) |=> cnt_r == $past(cnt_r) - 2'd1;
  endproperty
  a_pop_drops: assert property (p_pop_drops) else $error("pop count");

  property p_push_adds;
    @(posedge clk) disable iff (!rst_n) (do_push && !do_pop) |=> cnt_r == $past(cnt_r) + 2'd1;
  endproperty
  a_push_adds: assert property (p_push_adds) else $error("push count");
endmodule
`default_nettype wire

// ===== hw/rtl/lru_back.sv =====
// Back end: directory, recency ranks and result sequencing.
`timescale 1ns / 1ps
`default_nettype none
module lru_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [5:0]    cap,
  input  wire logic          q_valid,
  input  wire lru_pkg::req_t q_req,
  output logic               q_take,
  output logic               busy,
  output logic               out_empty,
  output lru_pkg::out_word_t out_word,
  input  wire logic          out_pop
);
  import lru_pkg::*;

  logic [KeyBits-1:0] key_r   [MaxEntries];
  logic               valid_r [MaxEntries];
  logic [IdxBits-1:0] rank_r  [MaxEntries];
  logic [CntBits-1:0] count_r;

  state_t state_r, state_nxt;
  req_t   req_r;
  logic   was_r;
  logic   ov_r;
  out_word_t ob_r;
  // Slot of a put hit; the hit stays resident when no eviction was needed.
  logic [IdxBits-1:0] hit_idx_r;

  logic               hit;
  logic [IdxBits-1:0] hit_idx;
  logic [IdxBits-1:0] free_idx;
  logic [IdxBits-1:0] old_idx;
  logic               has_old;
  logic [CntBits-1:0] eff_cap;
  logic               out_free;
  logic               start, need_evict;
  logic               emit_ev, emit_st;
  logic               do_install;

  always_comb begin
    if (cap == 6'd0) eff_cap = CntBits'(1);
    else if (cap > 6'(MaxEntries)) eff_cap = CntBits'(MaxEntries);
    else eff_cap = CntBits'(cap);
  end

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    has_old = 1'b0;
    old_idx = '0;
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == q_req.key) begin
        hit = 1'b1;
        hit_idx = IdxBits'(i);
      end
      if (!valid_r[i]) free_idx = IdxBits'(i);
      if (valid_r[i] && rank_r[i] == IdxBits'(count_r - 1'b1)) begin
        has_old = 1'b1;
        old_idx = IdxBits'(i);
      end
    end
  end

  assign out_free  = !ov_r || out_pop;
  assign out_empty = !ov_r;
  assign out_word  = ob_r;
  assign busy      = (state_r != ST_IDLE) || ov_r;

  // Count after the drop of a resident put.
  logic [CntBits-1:0] cnt_after;
  assign cnt_after = count_r - CntBits'(hit && q_req.op == OP_PUT);
  assign need_evict = cnt_after >= eff_cap && cnt_after != '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_valid) begin
        state_nxt = ST_STATUS;
        if ((q_req.op == OP_PUT || (q_req.op == OP_GET && !hit)) && need_evict)
          state_nxt = ST_EVICT;
      end
      ST_EVICT: if (out_free && (count_r - 1'b1 < eff_cap || count_r == CntBits'(1)))
        state_nxt = ST_STATUS;
      ST_STATUS: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    start   = (state_r == ST_IDLE) && q_valid;
    q_take  = start;
    emit_ev = (state_r == ST_EVICT) && out_free;
    emit_st = (state_r == ST_STATUS) && out_free;
  end

  // A new key is installed for put/get misses and for a dropped put hit.
  assign do_install = emit_st && (req_r.op == OP_PUT || req_r.op == OP_GET)
                      && !(req_r.op == OP_GET && was_r)
                      && !(req_r.op == OP_PUT && was_r && valid_r[hit_idx_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_r <= q_req;
      was_r <= hit;
    end
  end

  // Directory update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < MaxEntries; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i] <= '0;
      end
    end else if (start && hit && q_req.op != OP_PEEK) begin
      // Drop the hit on remove or evicting put; else move it to rank zero.
      for (int i = 0; i < MaxEntries; i++) begin
        if (valid_r[i] && IdxBits'(i) != hit_idx) begin
          if (q_req.op == OP_REMOVE) begin
            if (rank_r[i] > rank_r[hit_idx]) rank_r[i] <= rank_r[i] - 1'b1;
          end else if (q_req.op == OP_GET || !need_evict) begin
            if (rank_r[i] < rank_r[hit_idx]) rank_r[i] <= rank_r[i] + 1'b1;
          end else begin
            if (rank_r[i] > rank_r[hit_idx]) rank_r[i] <= rank_r[i] - 1'b1;
          end
        end
      end
      if (q_req.op == OP_REMOVE || (q_req.op == OP_PUT && need_evict)) begin
        valid_r[hit_idx] <= 1'b0;
        rank_r[hit_idx] <= '0;
        count_r <= count_r - 1'b1;
      end else begin
        rank_r[hit_idx] <= '0;
      end
    end else if (emit_ev) begin
      valid_r[old_idx] <= 1'b0;
      rank_r[old_idx] <= '0;
      count_r <= count_r - 1'b1;
    end else if (do_install) begin
      for (int i = 0; i < MaxEntries; i++)
        if (valid_r[i]) rank_r[i] <= rank_r[i] + 1'b1;
      valid_r[free_idx] <= 1'b1;
      rank_r[free_idx] <= '0;
      count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) hit_idx_r <= hit_idx;
  end

  always_ff @(posedge clk) begin
    if (do_install) key_r[free_idx] <= req_r.key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (emit_ev || emit_st) ov_r <= 1'b1;
    else if (out_pop) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit_ev) ob_r <= '{kind: 1'b0, result_key: 32'(key_r[old_idx]), was_resident: 1'b0,
                           last: 1'b0};
    else if (emit_st) ob_r <= '{kind: 1'b1, result_key: 32'(req_r.key), was_resident: was_r,
                                last: 1'b1};
  end

  property p_evict_has_victim;
    @(posedge clk) disable iff (!rst_n) emit_ev |-> has_old;
  endproperty
  a_evict_has_victim: assert property (p_evict_has_victim) else $error("no victim");

  property p_count_bound;
    @(posedge clk) disable iff (!rst_n) count_r <= CntBits'(MaxEntries);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("count over");

  property p_hold_out;
    @(posedge clk) disable iff (!rst_n) (ov_r && !out_pop) |=> $stable(ob_r);
  endproperty
  a_hold_out: assert property (p_hold_out) else $error("result lost");
endmodule
`default_nettype wire
